>>> rtl/core/ssep_pkg.sv
// Shared types and constants for the segment/sphere exit point block.
package ssep_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_reg_e;

  // Multiplier operand B is consumed this many bits per pipeline stage
  localparam int unsigned MUL_CHUNK = 16;

endpackage

>>> rtl/core/ssep_mul.sv
// Pipelined multi-lane unsigned multiplier, one chunk of operand B per stage.
module ssep_mul import ssep_pkg::*; #(
  parameter int unsigned AW    = 66,
  parameter int unsigned BW    = 66,
  parameter int unsigned LANES = 2,
  parameter int unsigned TW    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [LANES-1:0][AW-1:0]         a_i,
  input  logic [LANES-1:0][BW-1:0]         b_i,
  input  logic [TW-1:0]                    tag_i,
  output logic                             valid_o,
  output logic [LANES-1:0][AW+BW-1:0]      p_o,
  output logic [TW-1:0]                    tag_o
);

  localparam int unsigned ST  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned BPW = ST * MUL_CHUNK;
  localparam int unsigned PW  = AW + BW;

  logic                         vld_q [ST];
  logic [LANES-1:0][AW-1:0]     a_q   [ST];
  logic [LANES-1:0][BPW-1:0]    b_q   [ST];
  logic [LANES-1:0][PW-1:0]     acc_q [ST];
  logic [TW-1:0]                tag_q [ST];

  for (genvar j = 0; j < ST; j++) begin : g_st
    logic                             vld_in;
    logic [LANES-1:0][AW-1:0]         a_in;
    logic [LANES-1:0][BPW-1:0]        b_in;
    logic [LANES-1:0][PW-1:0]         acc_in;
    logic [TW-1:0]                    tag_in;
    logic [LANES-1:0][AW+MUL_CHUNK-1:0] pp;
    logic [LANES-1:0][PW-1:0]         acc_d;

    if (j == 0) begin : g_first
      always_comb begin
        vld_in = valid_i;
        a_in   = a_i;
        tag_in = tag_i;
        acc_in = '0;
        for (int l = 0; l < LANES; l++) begin
          b_in[l] = BPW'(b_i[l]);
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in = vld_q[j-1];
        a_in   = a_q[j-1];
        b_in   = b_q[j-1];
        acc_in = acc_q[j-1];
        tag_in = tag_q[j-1];
      end
    end

    // partial product of this chunk, shifted into place and accumulated
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        pp[l]    = a_in[l] * b_in[l][j*MUL_CHUNK +: MUL_CHUNK];
        acc_d[l] = acc_in[l] + (PW'(pp[l]) << (j * MUL_CHUNK));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[j]   <= a_in;
        b_q[j]   <= b_in;
        acc_q[j] <= acc_d;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[ST-1];
  assign p_o     = acc_q[ST-1];
  assign tag_o   = tag_q[ST-1];

endmodule

>>> rtl/core/ssep_sqrt.sv
// Pipelined integer square root (floor), one result bit per stage.
module ssep_sqrt #(
  parameter int unsigned DW = 133,
  parameter int unsigned TW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [DW-1:0]             rad_i,
  input  logic [TW-1:0]             tag_i,
  output logic                      valid_o,
  output logic [(DW+1)/2-1:0]       root_o,
  output logic [TW-1:0]             tag_o
);

  localparam int unsigned RW  = (DW + 1) / 2;
  localparam int unsigned TRW = 2 * RW + 1;

  logic            vld_q [RW];
  logic [DW-1:0]   rem_q [RW];
  logic [RW-1:0]   res_q [RW];
  logic [TW-1:0]   tag_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_st
    localparam int unsigned BI = RW - 1 - j;

    logic            vld_in;
    logic [DW-1:0]   rem_in;
    logic [RW-1:0]   res_in;
    logic [TW-1:0]   tag_in;
    logic [TRW-1:0]  trial;
    logic            take;
    logic [DW-1:0]   rem_d;
    logic [RW-1:0]   res_d;

    if (j == 0) begin : g_first
      always_comb begin
        vld_in = valid_i;
        rem_in = rad_i;
        res_in = '0;
        tag_in = tag_i;
      end
    end else begin : g_next
      always_comb begin
        vld_in = vld_q[j-1];
        rem_in = rem_q[j-1];
        res_in = res_q[j-1];
        tag_in = tag_q[j-1];
      end
    end

    // (res + 2^i)^2 - res^2 = res*2^(i+1) + 2^(2i)
    always_comb begin
      trial = (TRW'(res_in) << (BI + 1)) | (TRW'(1) << (2 * BI));
      take  = TRW'(rem_in) >= trial;
      rem_d = take ? DW'(TRW'(rem_in) - trial) : rem_in;
      res_d = take ? (res_in | (RW'(1) << BI)) : res_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        res_q[j] <= res_d;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = res_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

>>> rtl/core/ssep_div.sv
// Pipelined multi-lane restoring divider with a shared divisor and overflow flag.
module ssep_div #(
  parameter int unsigned NW    = 100,
  parameter int unsigned DVW   = 66,
  parameter int unsigned QW    = 33,
  parameter int unsigned LANES = 3,
  parameter int unsigned TW    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][NW-1:0]     num_i,
  input  logic [DVW-1:0]               dv_i,
  input  logic [TW-1:0]                tag_i,
  output logic                         valid_o,
  output logic [LANES-1:0][QW-1:0]     quo_o,
  output logic [LANES-1:0]             ovf_o,
  output logic [TW-1:0]                tag_o
);

  localparam int unsigned CW = ((NW > DVW + QW) ? NW : DVW + QW) + 1;
  localparam int unsigned NS = QW + 1;

  logic                       vld_q [NS];
  logic [LANES-1:0][NW-1:0]   rem_q [NS];
  logic [LANES-1:0][QW-1:0]   quo_q [NS];
  logic [LANES-1:0]           ovf_q [NS];
  logic [DVW-1:0]             dv_q  [NS];
  logic [TW-1:0]              tag_q [NS];

  // Front stage: quotient would not fit in QW bits
  logic [LANES-1:0] ovf_d;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ovf_d[l] = CW'(num_i[l]) >= (CW'(dv_i) << QW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
      dv_q[0]  <= dv_i;
      tag_q[0] <= tag_i;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s < NS; s++) begin : g_st
    localparam int unsigned BI = QW - s;

    logic [CW-1:0]             sub;
    logic [LANES-1:0]          take;
    logic [LANES-1:0][NW-1:0]  rem_d;
    logic [LANES-1:0][QW-1:0]  quo_d;

    always_comb begin
      sub = CW'(dv_q[s-1]) << BI;
      for (int l = 0; l < LANES; l++) begin
        take[l]  = CW'(rem_q[s-1][l]) >= sub;
        rem_d[l] = take[l] ? NW'(CW'(rem_q[s-1][l]) - sub) : rem_q[s-1][l];
        quo_d[l] = take[l] ? (quo_q[s-1][l] | (QW'(1) << BI)) : quo_q[s-1][l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        ovf_q[s] <= ovf_q[s-1];
        dv_q[s]  <= dv_q[s-1];
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign ovf_o   = ovf_q[NS-1];
  assign tag_o   = tag_q[NS-1];

endmodule

>>> rtl/core/segment_sphere_exit_point.sv
// Throughput: one item per cycle unless the output stalls; the square root (one bit
//   per stage) and the divider (one quotient bit per stage) set the depth, not the rate.
// Reset: asynchronous, active low; clears all valid bits and the sphere registers to 0.
// Top level: far intersection of a segment's line with a configured sphere.
module segment_sphere_exit_point import ssep_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  // result item channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o,
  output logic signed [COORD_WIDTH-1:0] point_z_o,
  output logic                          hit_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned PW  = 2 * W;       // one square or cross product
  localparam int unsigned SW  = 2 * W + 2;   // sum of three products
  localparam int unsigned DW  = 2 * SW + 1;  // discriminant
  localparam int unsigned RW  = (DW + 1) / 2;
  localparam int unsigned NW  = RW + 1;      // sqrt(D) -/+ h
  localparam int unsigned PRW = NW + W;
  localparam int unsigned QW  = W + 1;

  typedef logic [2:0][W-1:0] vec_t;

  typedef struct packed {
    logic [SW-1:0] a;
    logic [SW-1:0] habs;
    logic          hneg;
    logic          cneg;
    logic          azero;
    vec_t          dmag;
    logic [2:0]    dneg;
    vec_t          s;
    vec_t          e;
  } m1_tag_t;

  typedef struct packed {
    logic [SW-1:0] a;
    logic [SW-1:0] habs;
    logic          hneg;
    logic          miss;
    vec_t          dmag;
    logic [2:0]    dneg;
    vec_t          s;
    vec_t          e;
  } sq_tag_t;

  typedef struct packed {
    logic [SW-1:0] a;
    logic          nneg;
    logic          miss;
    logic [2:0]    dneg;
    vec_t          s;
    vec_t          e;
  } m2_tag_t;

  typedef struct packed {
    logic          nneg;
    logic          miss;
    logic [2:0]    dneg;
    vec_t          s;
    vec_t          e;
  } dv_tag_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [W-1:0]   center_x_q, center_y_q, center_z_q;
  logic [W-2:0]   radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        CFG_CENTER_Z: center_z_q <= cfg_data_i;
        CFG_RADIUS:   radius_q   <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Advance the pipeline unless last stage and output register are full and output stalls
  logic pipe_en;
  logic res_vld_q;
  logic out_vld_q;

  assign pipe_en    = !(res_vld_q && out_vld_q && out_stall_i);
  assign in_stall_o = !pipe_en;

  // ---------------------------------------------------------------------------
  // P1: direction d = E - S and offset o = S - center, as sign and magnitude
  vec_t           in_s, in_e, cen;
  logic [2:0][W:0] d_w, o_w;
  vec_t           p1_dmag_d, p1_omag_d;
  logic [2:0]     p1_dneg_d, p1_oneg_d;

  logic           p1_vld_q;
  vec_t           p1_s_q, p1_e_q, p1_dmag_q, p1_omag_q;
  logic [2:0]     p1_dneg_q, p1_oneg_q;

  assign in_s = {start_z_i, start_y_i, start_x_i};
  assign in_e = {end_z_i, end_y_i, end_x_i};
  assign cen  = {center_z_q, center_y_q, center_x_q};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i] = {in_e[i][W-1], in_e[i]} - {in_s[i][W-1], in_s[i]};
      o_w[i] = {in_s[i][W-1], in_s[i]} - {cen[i][W-1], cen[i]};
      p1_dneg_d[i] = d_w[i][W];
      p1_oneg_d[i] = o_w[i][W];
      p1_dmag_d[i] = d_w[i][W] ? W'(~d_w[i] + 1'b1) : d_w[i][W-1:0];
      p1_omag_d[i] = o_w[i][W] ? W'(~o_w[i] + 1'b1) : o_w[i][W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (pipe_en) begin
      p1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_s_q    <= in_s;
      p1_e_q    <= in_e;
      p1_dmag_q <= p1_dmag_d;
      p1_omag_q <= p1_omag_d;
      p1_dneg_q <= p1_dneg_d;
      p1_oneg_q <= p1_oneg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // P2: per-axis products d*d, o*o, d*o and r*r
  logic [2:0][PW-1:0] p2_dd_d, p2_oo_d, p2_do_d;
  logic [PW-1:0]      p2_rr_d;

  logic               p2_vld_q;
  logic [2:0][PW-1:0] p2_dd_q, p2_oo_q, p2_do_q;
  logic [PW-1:0]      p2_rr_q;
  logic [2:0]         p2_hsn_q;
  vec_t               p2_s_q, p2_e_q, p2_dmag_q;
  logic [2:0]         p2_dneg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2_dd_d[i] = p1_dmag_q[i] * p1_dmag_q[i];
      p2_oo_d[i] = p1_omag_q[i] * p1_omag_q[i];
      p2_do_d[i] = p1_dmag_q[i] * p1_omag_q[i];
    end
    p2_rr_d = radius_q * radius_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (pipe_en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p2_dd_q   <= p2_dd_d;
      p2_oo_q   <= p2_oo_d;
      p2_do_q   <= p2_do_d;
      p2_rr_q   <= p2_rr_d;
      p2_hsn_q  <= p1_dneg_q ^ p1_oneg_q;
      p2_s_q    <= p1_s_q;
      p2_e_q    <= p1_e_q;
      p2_dmag_q <= p1_dmag_q;
      p2_dneg_q <= p1_dneg_q;
    end
  end

  // ---------------------------------------------------------------------------
  // P3: a = |d|^2, |o|^2, and d.o split into positive and negative parts
  logic [SW-1:0] p3_a_d, p3_cp_d, p3_hp_d, p3_hn_d;

  logic          p3_vld_q;
  logic [SW-1:0] p3_a_q, p3_cp_q, p3_hp_q, p3_hn_q;
  logic [PW-1:0] p3_rr_q;
  vec_t          p3_s_q, p3_e_q, p3_dmag_q;
  logic [2:0]    p3_dneg_q;

  always_comb begin
    p3_a_d  = SW'(p2_dd_q[0]) + SW'(p2_dd_q[1]) + SW'(p2_dd_q[2]);
    p3_cp_d = SW'(p2_oo_q[0]) + SW'(p2_oo_q[1]) + SW'(p2_oo_q[2]);
    p3_hp_d = '0;
    p3_hn_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (p2_hsn_q[i]) begin
        p3_hn_d = p3_hn_d + SW'(p2_do_q[i]);
      end else begin
        p3_hp_d = p3_hp_d + SW'(p2_do_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (pipe_en) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p3_a_q    <= p3_a_d;
      p3_cp_q   <= p3_cp_d;
      p3_hp_q   <= p3_hp_d;
      p3_hn_q   <= p3_hn_d;
      p3_rr_q   <= p2_rr_q;
      p3_s_q    <= p2_s_q;
      p3_e_q    <= p2_e_q;
      p3_dmag_q <= p2_dmag_q;
      p3_dneg_q <= p2_dneg_q;
    end
  end

  // ---------------------------------------------------------------------------
  // P4: h = d.o and c = |o|^2 - r^2 as sign and magnitude
  m1_tag_t       p4_tag_d;
  logic [SW-1:0] p4_cabs_d;

  logic          p4_vld_q;
  m1_tag_t       p4_tag_q;
  logic [SW-1:0] p4_cabs_q;

  always_comb begin
    p4_tag_d.a     = p3_a_q;
    p4_tag_d.hneg  = p3_hp_q < p3_hn_q;
    p4_tag_d.habs  = p4_tag_d.hneg ? (p3_hn_q - p3_hp_q) : (p3_hp_q - p3_hn_q);
    p4_tag_d.cneg  = p3_cp_q < SW'(p3_rr_q);
    p4_tag_d.azero = (p3_a_q == '0);
    p4_tag_d.dmag  = p3_dmag_q;
    p4_tag_d.dneg  = p3_dneg_q;
    p4_tag_d.s     = p3_s_q;
    p4_tag_d.e     = p3_e_q;
    p4_cabs_d      = p4_tag_d.cneg ? (SW'(p3_rr_q) - p3_cp_q) : (p3_cp_q - SW'(p3_rr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else if (pipe_en) begin
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p4_tag_q  <= p4_tag_d;
      p4_cabs_q <= p4_cabs_d;
    end
  end

  // ---------------------------------------------------------------------------
  // h^2 (lane 0) and a*|c| (lane 1)
  logic                 m1_vld;
  logic [1:0][2*SW-1:0] m1_p;
  m1_tag_t              m1_tag;

  ssep_mul #(
    .AW    (SW),
    .BW    (SW),
    .LANES (2),
    .TW    ($bits(m1_tag_t))
  ) u_mul_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (p4_vld_q),
    .a_i     ({p4_tag_q.a, p4_tag_q.habs}),
    .b_i     ({p4_cabs_q, p4_tag_q.habs}),
    .tag_i   (p4_tag_q),
    .valid_o (m1_vld),
    .p_o     (m1_p),
    .tag_o   (m1_tag)
  );

  // ---------------------------------------------------------------------------
  // P5: reduced discriminant D = h^2 - a*c and the miss decision
  logic [DW-1:0] p5_disc_d;
  sq_tag_t       p5_tag_d;

  logic          p5_vld_q;
  logic [DW-1:0] p5_disc_q;
  sq_tag_t       p5_tag_q;

  always_comb begin
    p5_disc_d = m1_tag.cneg ? (DW'(m1_p[0]) + DW'(m1_p[1]))
                            : (DW'(m1_p[0]) - DW'(m1_p[1]));
    p5_tag_d.a    = m1_tag.a;
    p5_tag_d.habs = m1_tag.habs;
    p5_tag_d.hneg = m1_tag.hneg;
    p5_tag_d.miss = m1_tag.azero || (!m1_tag.cneg && (m1_p[0] < m1_p[1]));
    p5_tag_d.dmag = m1_tag.dmag;
    p5_tag_d.dneg = m1_tag.dneg;
    p5_tag_d.s    = m1_tag.s;
    p5_tag_d.e    = m1_tag.e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q <= 1'b0;
    end else if (pipe_en) begin
      p5_vld_q <= m1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p5_disc_q <= p5_disc_d;
      p5_tag_q  <= p5_tag_d;
    end
  end

  // ---------------------------------------------------------------------------
  // floor(sqrt(D))
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  sq_tag_t       sq_tag;

  ssep_sqrt #(
    .DW (DW),
    .TW ($bits(sq_tag_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (p5_vld_q),
    .rad_i   (p5_disc_q),
    .tag_i   (p5_tag_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  // ---------------------------------------------------------------------------
  // P6: numerator sqrt(D) - h as sign and magnitude
  logic [NW-1:0] p6_num_d;
  m2_tag_t       p6_tag_d;

  logic          p6_vld_q;
  logic [NW-1:0] p6_num_q;
  vec_t          p6_dmag_q;
  m2_tag_t       p6_tag_q;

  always_comb begin
    p6_tag_d.nneg = 1'b0;
    if (sq_tag.hneg) begin
      p6_num_d = NW'(sq_root) + NW'(sq_tag.habs);
    end else if (sq_root >= RW'(sq_tag.habs)) begin
      p6_num_d = NW'(sq_root) - NW'(sq_tag.habs);
    end else begin
      p6_num_d      = NW'(sq_tag.habs) - NW'(sq_root);
      p6_tag_d.nneg = 1'b1;
    end
    p6_tag_d.a    = sq_tag.a;
    p6_tag_d.miss = sq_tag.miss;
    p6_tag_d.dneg = sq_tag.dneg;
    p6_tag_d.s    = sq_tag.s;
    p6_tag_d.e    = sq_tag.e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_vld_q <= 1'b0;
    end else if (pipe_en) begin
      p6_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p6_num_q  <= p6_num_d;
      p6_dmag_q <= sq_tag.dmag;
      p6_tag_q  <= p6_tag_d;
    end
  end

  // ---------------------------------------------------------------------------
  // numerator times |d_i| on each axis
  logic                m2_vld;
  logic [2:0][PRW-1:0] m2_p;
  m2_tag_t             m2_tag;
  dv_tag_t             m2_dvtag;

  ssep_mul #(
    .AW    (NW),
    .BW    (W),
    .LANES (3),
    .TW    ($bits(m2_tag_t))
  ) u_mul_axis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (p6_vld_q),
    .a_i     ({p6_num_q, p6_num_q, p6_num_q}),
    .b_i     (p6_dmag_q),
    .tag_i   (p6_tag_q),
    .valid_o (m2_vld),
    .p_o     (m2_p),
    .tag_o   (m2_tag)
  );

  always_comb begin
    m2_dvtag.nneg = m2_tag.nneg;
    m2_dvtag.miss = m2_tag.miss;
    m2_dvtag.dneg = m2_tag.dneg;
    m2_dvtag.s    = m2_tag.s;
    m2_dvtag.e    = m2_tag.e;
  end

  // ---------------------------------------------------------------------------
  // per-axis offset magnitude = product / a
  logic               dv_vld;
  logic [2:0][QW-1:0] dv_quo;
  logic [2:0]         dv_ovf;
  dv_tag_t            dv_tag;

  ssep_div #(
    .NW    (PRW),
    .DVW   (SW),
    .QW    (QW),
    .LANES (3),
    .TW    ($bits(dv_tag_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (m2_vld),
    .num_i   (m2_p),
    .dv_i    (m2_tag.a),
    .tag_i   (m2_dvtag),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .tag_o   (dv_tag)
  );

  // ---------------------------------------------------------------------------
  // P7: S + signed offset, saturated per axis; end point on a miss
  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic [2:0][W+1:0] off_w, sum_w;
  logic [2:0]        neg_w;
  vec_t              res_pt_d;

  vec_t              res_pt_q;
  logic              res_hit_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_w[i] = dv_tag.nneg ^ dv_tag.dneg[i];
      off_w[i] = (W+2)'(dv_quo[i][W-1:0]);
      if (neg_w[i]) begin
        off_w[i] = ~off_w[i] + 1'b1;
      end
      sum_w[i] = {dv_tag.s[i][W-1], dv_tag.s[i][W-1], dv_tag.s[i]} + off_w[i];
      if (dv_tag.miss) begin
        res_pt_d[i] = dv_tag.e[i];
      end else if (dv_ovf[i] || dv_quo[i][W]) begin
        res_pt_d[i] = neg_w[i] ? SAT_MIN : SAT_MAX;
      end else if (sum_w[i][W+1:W-1] != 3'b000 && sum_w[i][W+1:W-1] != 3'b111) begin
        res_pt_d[i] = sum_w[i][W+1] ? SAT_MIN : SAT_MAX;
      end else begin
        res_pt_d[i] = sum_w[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (pipe_en) begin
      res_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      res_pt_q  <= res_pt_d;
      res_hit_q <= !dv_tag.miss;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result while the pipeline keeps filling
  vec_t out_pt_q;
  logic out_hit_q;
  logic out_load;

  assign out_load = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= res_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pt_q  <= res_pt_q;
      out_hit_q <= res_hit_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign point_x_o   = out_pt_q[0];
  assign point_y_o   = out_pt_q[1];
  assign point_z_o   = out_pt_q[2];
  assign hit_o       = out_hit_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i && res_vld_q))
    else $error("input stalled without output backpressure");

  a_res_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && pipe_en) |=> out_vld_q)
    else $error("finished item lost between last stage and output register");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_stall_i && !res_vld_q) |=> !out_vld_q)
    else $error("result item repeated after being taken");

endmodule
